// ===== rtl/core/fdtb_pkg.sv =====
// ----------------------------------------------------------------------------
// fdtb_pkg
// Shared codes, widths and limits of the frame driven timer bank.
// ----------------------------------------------------------------------------
package fdtb_pkg;

	localparam int OP_W     = 2;
	localparam int IDX_W    = 5;
	localparam int DUR_W    = 32;
	localparam int FRAME_W  = 10;
	localparam int SUB_W    = 4;
	localparam int KIND_W   = 2;
	localparam int TIME_W   = 48;
	localparam int ORDER_W  = 32;
	localparam int SLOT_W   = TIME_W + ORDER_W;

	localparam int MAX_RESULTS = 32;
	localparam int CNT_W       = 6;

	localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
	localparam logic [OP_W-1:0] OP_START  = 2'd1;
	localparam logic [OP_W-1:0] OP_STOP   = 2'd2;
	localparam logic [OP_W-1:0] OP_EXPIRE = 2'd3;

	localparam logic [KIND_W-1:0] KIND_ACK     = 2'd0;
	localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd1;
	localparam logic [KIND_W-1:0] KIND_NONE    = 2'd2;

	typedef logic [OP_W-1:0]    op_t;
	typedef logic [KIND_W-1:0]  kind_t;
	typedef logic [TIME_W-1:0]  time_t;
	typedef logic [ORDER_W-1:0] order_t;

endpackage

// ===== rtl/core/fdtb_req_if.sv =====
// ----------------------------------------------------------------------------
// fdtb_req_if
// Request channel of the timer bank: valid/ready with one command item.
// ----------------------------------------------------------------------------
interface fdtb_req_if import fdtb_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [OP_W-1:0]      operation;
	logic [IDX_W-1:0]     timer_index;
	logic [DUR_W-1:0]     duration;
	logic [FRAME_W-1:0]   frame_number;
	logic [SUB_W-1:0]     subframe_number;

	modport source (
		output valid, operation, timer_index, duration, frame_number, subframe_number,
		input  ready
	);
	modport sink (
		input  valid, operation, timer_index, duration, frame_number, subframe_number,
		output ready
	);
endinterface

// ===== rtl/core/fdtb_rsp_if.sv =====
// ----------------------------------------------------------------------------
// fdtb_rsp_if
// Response channel of the timer bank: valid/ready with one result item.
// ----------------------------------------------------------------------------
interface fdtb_rsp_if import fdtb_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [KIND_W-1:0]    result_kind;
	logic [IDX_W-1:0]     expired_index;
	logic                 error;
	logic [TIME_W-1:0]    current_time;
	logic                 last;

	modport source (
		output valid, result_kind, expired_index, error, current_time, last,
		input  ready
	);
	modport sink (
		input  valid, result_kind, expired_index, error, current_time, last,
		output ready
	);
endinterface

// ===== rtl/core/fdtb_ram.sv =====
// ----------------------------------------------------------------------------
// fdtb_ram
// Simple dual port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fdtb_ram #(
	parameter int WIDTH = 80,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/frame_driven_timer_bank.sv =====
// ----------------------------------------------------------------------------
// frame_driven_timer_bank
// Timer slots on a millisecond clock taken from frame/subframe ticks.
// Slot deadlines and start order live in one RAM; expire rescans the RAM
// once per reported slot to pick the earliest deadline, oldest start first.
// ----------------------------------------------------------------------------
// Tick, start and stop pass through EXEC and then the result register; req.ready
// is high only in IDLE, so no new command is taken until the result is loaded.
// Expire: a decode step in EXEC, then a RAM scan pass (SCAN, DRAIN, FINISH) per due
// slot plus one closing pass, which is left out when MAX_RESULTS slots are reported.
// Reset clears time, frame history, start counter and all running flags at
// once; the slot RAM is not cleared, its entries only count for running slots.
module frame_driven_timer_bank import fdtb_pkg::*; #(
	parameter int NUM_TIMERS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	fdtb_req_if.sink      req,
	fdtb_rsp_if.source    rsp
);

	localparam int IW = $clog2(NUM_TIMERS);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_EXEC   = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_DRAIN  = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;

	logic [2:0]            state_q;

	// captured item
	op_t                   op_q;
	logic [IDX_W-1:0]      idx_q;
	logic [DUR_W-1:0]      dur_q;
	logic [FRAME_W-1:0]    frame_q;
	logic [SUB_W-1:0]      sub_q;

	// timebase and bank state
	time_t                 now_q;
	logic [FRAME_W-1:0]    last_frame_q;
	logic [SUB_W-1:0]      last_sub_q;
	order_t                counter_q;
	logic [NUM_TIMERS-1:0] running_q;

	// scan
	logic [IW-1:0]         addr_q;
	logic                  vld_s1;
	logic [IW-1:0]         idx_s1;
	logic                  best_vld_q;
	logic [IW-1:0]         best_idx_q;
	time_t                 best_dl_q;
	order_t                best_age_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  pend_vld_q;
	logic [IW-1:0]         pend_idx_q;

	// result register
	logic                  out_vld_q;
	kind_t                 out_kind_q;
	logic [IDX_W-1:0]      out_idx_q;
	logic                  out_err_q;
	time_t                 out_time_q;
	logic                  out_last_q;

	logic                  can_load;
	logic                  idx_ok;
	logic                  tick_adv;
	time_t                 now_nx;
	logic                  start_ok;
	logic                  ram_we;
	logic [SLOT_W-1:0]     ram_wdata;
	logic [SLOT_W-1:0]     ram_rdata;
	time_t                 rd_dl;
	order_t                rd_age;
	logic                  due_s1;
	logic                  better_s1;
	logic                  ld;
	kind_t                 ld_kind;
	logic [IW-1:0]         ld_idx;
	logic                  ld_err;
	logic                  ld_last;
	logic                  fin_go;

	assign can_load  = !out_vld_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE);

	assign idx_ok   = {2'b00, idx_q} < 7'(NUM_TIMERS);
	assign tick_adv = (op_q == OP_TICK) && ((frame_q != last_frame_q) || (sub_q != last_sub_q));
	assign now_nx   = tick_adv ? now_q + 48'd1 : now_q;
	assign start_ok = (op_q == OP_START) && (dur_q != '0) && idx_ok;

	assign ram_we    = (state_q == ST_EXEC) && start_ok && can_load;
	assign ram_wdata = {counter_q, now_q + TIME_W'(dur_q)};

	fdtb_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (NUM_TIMERS)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (IW'(idx_q)),
		.wdata (ram_wdata),
		.raddr (addr_q),
		.rdata (ram_rdata)
	);

	// compare stage: earliest deadline, then oldest start
	assign rd_dl     = ram_rdata[TIME_W-1:0];
	assign rd_age    = counter_q - ram_rdata[SLOT_W-1:TIME_W];
	assign due_s1    = vld_s1 && running_q[idx_s1] && (rd_dl <= now_q);
	assign better_s1 = !best_vld_q || (rd_dl < best_dl_q) ||
	                   ((rd_dl == best_dl_q) && (rd_age > best_age_q));

	// result selection
	always_comb begin
		ld      = 1'b0;
		ld_kind = KIND_ACK;
		ld_idx  = '0;
		ld_err  = 1'b0;
		ld_last = 1'b1;
		fin_go  = 1'b0;
		case (state_q)
			ST_EXEC: begin
				if (op_q != OP_EXPIRE && can_load) begin
					ld     = 1'b1;
					ld_err = (op_q == OP_START) && (dur_q == '0);
				end
			end
			ST_FINISH: begin
				if (best_vld_q) begin
					// hold the new slot; the previous one is known not to be last
					fin_go = !pend_vld_q || can_load;
					if (pend_vld_q && can_load) begin
						ld      = 1'b1;
						ld_kind = KIND_EXPIRED;
						ld_idx  = pend_idx_q;
						ld_last = 1'b0;
					end
				end else if (can_load) begin
					fin_go  = 1'b1;
					ld      = 1'b1;
					ld_kind = pend_vld_q ? KIND_EXPIRED : KIND_NONE;
					ld_idx  = pend_vld_q ? pend_idx_q : '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.valid) begin
			op_q    <= req.operation;
			idx_q   <= req.timer_index;
			dur_q   <= req.duration;
			frame_q <= req.frame_number;
			sub_q   <= req.subframe_number;
		end
		idx_s1 <= addr_q;
		if (due_s1 && better_s1) begin
			best_idx_q <= idx_s1;
			best_dl_q  <= rd_dl;
			best_age_q <= rd_age;
		end
		if (ld) begin
			out_kind_q <= ld_kind;
			out_idx_q  <= IDX_W'(ld_idx);
			out_err_q  <= ld_err;
			out_time_q <= (state_q == ST_EXEC) ? now_nx : now_q;
			out_last_q <= ld_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			now_q        <= '0;
			last_frame_q <= '0;
			last_sub_q   <= '0;
			counter_q    <= '0;
			running_q    <= '0;
			addr_q       <= '0;
			vld_s1       <= 1'b0;
			best_vld_q   <= 1'b0;
			cnt_q        <= '0;
			pend_vld_q   <= 1'b0;
			pend_idx_q   <= '0;
			out_vld_q    <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_SCAN);
			if (due_s1 && better_s1) begin
				best_vld_q <= 1'b1;
			end
			if (ld) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (op_q == OP_EXPIRE) begin
						cnt_q      <= '0;
						pend_vld_q <= 1'b0;
						best_vld_q <= 1'b0;
						addr_q     <= '0;
						state_q    <= ST_SCAN;
					end else if (can_load) begin
						if (tick_adv) begin
							now_q        <= now_nx;
							last_frame_q <= frame_q;
							last_sub_q   <= sub_q;
						end
						if (start_ok) begin
							running_q[IW'(idx_q)] <= 1'b1;
							counter_q             <= counter_q + 32'd1;
						end
						if (op_q == OP_STOP && idx_ok) begin
							running_q[IW'(idx_q)] <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == IW'(NUM_TIMERS - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (fin_go) begin
						if (best_vld_q) begin
							running_q[best_idx_q] <= 1'b0;
							pend_vld_q            <= 1'b1;
							pend_idx_q            <= best_idx_q;
							cnt_q                 <= cnt_q + 1'b1;
							best_vld_q            <= 1'b0;
							addr_q                <= '0;
							// stop at the result cap: close out with the held slot
							if (cnt_q + 1'b1 != CNT_W'(MAX_RESULTS)) begin
								state_q <= ST_SCAN;
							end
						end else begin
							pend_vld_q <= 1'b0;
							state_q    <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid         = out_vld_q;
	assign rsp.result_kind   = out_kind_q;
	assign rsp.expired_index = out_idx_q;
	assign rsp.error         = out_err_q;
	assign rsp.current_time  = out_time_q;
	assign rsp.last          = out_last_q;

endmodule

// ===== test/tb_frame_driven_timer_bank.sv =====
// ----------------------------------------------------------------------------
// tb_frame_driven_timer_bank
// Self-checking bench for the frame driven timer bank. A behavioral copy of
// the bank predicts every result of each command transfer; a monitor compares
// the result stream field by field. Directed cases come first, then random
// traffic under several idle/stall mixes and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_frame_driven_timer_bank import fdtb_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int BANK_SLOTS   = 32;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 2 * (BANK_SLOTS + 3) + 20;
	localparam int HOLD_CYCLES  = 300;

	typedef logic [IDX_W-1:0]   slot_t;
	typedef logic [DUR_W-1:0]   dur_t;
	typedef logic [FRAME_W-1:0] frame_t;
	typedef logic [SUB_W-1:0]   sub_t;

	typedef struct packed {
		kind_t kind;
		slot_t slot;
		logic  err;
		time_t at_ms;
		logic  last;
	} timer_report_t;

	logic clk = 1'b0;
	logic arst_n;

	fdtb_req_if req_ch ();
	fdtb_rsp_if rsp_ch ();

	frame_driven_timer_bank #(
		.NUM_TIMERS(BANK_SLOTS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #5 clk = ~clk;

	// bank state as the bench sees it
	time_t  ms_now;
	frame_t seen_frame;
	sub_t   seen_sub;
	time_t  slot_deadline_ms [BANK_SLOTS];
	bit     slot_armed [BANK_SLOTS];
	order_t slot_arm_seq [BANK_SLOTS];
	order_t arm_count;

	timer_report_t pending_reports [$];

	// frame/subframe pair the stimulus will tick from
	frame_t radio_frame;
	sub_t   radio_sub;

	int idle_pct;
	int stall_pct;
	int hold_requests;
	int hold_served;
	int hold_left;

	int cycle_count;
	int error_count;
	int commands_sent;
	int results_checked;
	int expiry_reports;
	int largest_burst;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d results outstanding",
				$time, cycle_count, pending_reports.size());
			$display("simulation failed");
			$finish;
		end
	end

	// result side: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_requests != hold_served) begin
			hold_served = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic report_mismatch(input string field, input longint unsigned want,
			input longint unsigned got);
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		error_count++;
	endtask

	always @(posedge clk) begin
		timer_report_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_reports.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual kind %0d slot %0d time %0d",
					$time, rsp_ch.result_kind, rsp_ch.expired_index, rsp_ch.current_time);
				error_count++;
			end else begin
				want = pending_reports.pop_front();
				results_checked++;
				if (rsp_ch.result_kind !== want.kind)
					report_mismatch("result_kind", want.kind, rsp_ch.result_kind);
				if (rsp_ch.expired_index !== want.slot)
					report_mismatch("expired_index", want.slot, rsp_ch.expired_index);
				if (rsp_ch.error !== want.err)
					report_mismatch("error", want.err, rsp_ch.error);
				if (rsp_ch.current_time !== want.at_ms)
					report_mismatch("current_time", want.at_ms, rsp_ch.current_time);
				if (rsp_ch.last !== want.last)
					report_mismatch("last", want.last, rsp_ch.last);
			end
		end
	end

	task automatic push_report(input kind_t kind, input slot_t slot, input logic err,
			input logic last);
		timer_report_t r;
		r.kind = kind;
		r.slot = slot;
		r.err = err;
		r.at_ms = ms_now;
		r.last = last;
		pending_reports.push_back(r);
	endtask

	// update the bank copy for one accepted command and queue its results
	task automatic predict_timer_command(input op_t op, input slot_t idx, input dur_t dur,
			input frame_t frame, input sub_t sub);
		int picked [BANK_SLOTS];
		int due;
		int best;
		logic err;
		order_t age_i;
		order_t age_b;
		due = 0;
		err = 1'b0;
		case (op)
			OP_TICK: begin
				if (frame != seen_frame || sub != seen_sub) begin
					seen_frame = frame;
					seen_sub = sub;
					ms_now = ms_now + 1'b1;
				end
			end
			OP_START: begin
				if (dur == '0) begin
					err = 1'b1;
				end else if (int'(idx) < BANK_SLOTS) begin
					slot_deadline_ms[idx] = ms_now + time_t'(dur);
					slot_armed[idx] = 1'b1;
					slot_arm_seq[idx] = arm_count;
					arm_count = arm_count + 1'b1;
				end
			end
			OP_STOP: begin
				if (int'(idx) < BANK_SLOTS)
					slot_armed[idx] = 1'b0;
			end
			default: begin
				// pick earliest deadline, oldest start on a tie, until none is due or MAX_RESULTS are picked
				best = 0;
				while (best >= 0 && due < MAX_RESULTS) begin
					best = -1;
					for (int i = 0; i < BANK_SLOTS; i++) begin
						if (!slot_armed[i] || slot_deadline_ms[i] > ms_now)
							continue;
						if (best < 0 || slot_deadline_ms[i] < slot_deadline_ms[best]) begin
							best = i;
						end else if (slot_deadline_ms[i] == slot_deadline_ms[best]) begin
							age_i = arm_count - slot_arm_seq[i];
							age_b = arm_count - slot_arm_seq[best];
							if (age_i > age_b)
								best = i;
						end
					end
					if (best >= 0) begin
						slot_armed[best] = 1'b0;
						picked[due] = best;
						due++;
					end
				end
			end
		endcase
		if (op == OP_EXPIRE && due > 0) begin
			for (int k = 0; k < due; k++)
				push_report(KIND_EXPIRED, slot_t'(picked[k]), 1'b0, k == due - 1);
			expiry_reports += due;
			if (due > largest_burst)
				largest_burst = due;
		end else begin
			push_report((op == OP_EXPIRE) ? KIND_NONE : KIND_ACK, '0, err, 1'b1);
		end
	endtask

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic send_command(input op_t op, input slot_t idx, input dur_t dur,
			input frame_t frame, input sub_t sub);
		while ($urandom_range(99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			req_ch.operation <= op_t'($urandom);
			req_ch.timer_index <= slot_t'($urandom);
			req_ch.duration <= dur_t'($urandom);
			req_ch.frame_number <= frame_t'($urandom);
			req_ch.subframe_number <= sub_t'($urandom_range(9));
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.operation <= op;
		req_ch.timer_index <= idx;
		req_ch.duration <= dur;
		req_ch.frame_number <= frame;
		req_ch.subframe_number <= sub;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
		predict_timer_command(op, idx, dur, frame, sub);
		commands_sent++;
	endtask

	task automatic send_tick_at(input frame_t frame, input sub_t sub);
		radio_frame = frame;
		radio_sub = sub;
		send_command(OP_TICK, slot_t'($urandom), dur_t'($urandom), frame, sub);
	endtask

	// advance the radio pair normally, jump now and then, or repeat it
	task automatic send_tick(input bit advance);
		frame_t f;
		sub_t s;
		f = radio_frame;
		s = radio_sub;
		if (advance) begin
			if ($urandom_range(19) == 0) begin
				f = frame_t'($urandom);
				s = sub_t'($urandom_range(9));
			end else if (s == sub_t'(9)) begin
				s = '0;
				f = f + 1'b1;
			end else begin
				s = s + 1'b1;
			end
		end
		send_tick_at(f, s);
	endtask

	task automatic send_start(input slot_t idx, input dur_t dur);
		send_command(OP_START, idx, dur, frame_t'($urandom), sub_t'($urandom_range(9)));
	endtask

	task automatic send_stop(input slot_t idx);
		send_command(OP_STOP, idx, dur_t'($urandom), frame_t'($urandom),
			sub_t'($urandom_range(9)));
	endtask

	task automatic send_expire();
		send_command(OP_EXPIRE, slot_t'($urandom), dur_t'($urandom), frame_t'($urandom),
			sub_t'($urandom_range(9)));
	endtask

	function automatic dur_t pick_duration();
		int roll;
		roll = $urandom_range(99);
		if (roll < 5)
			return '0;
		if (roll < 85)
			return dur_t'($urandom_range(1, 12));
		if (roll < 95)
			return dur_t'($urandom_range(13, 300));
		return dur_t'($urandom);
	endfunction

	// arm n distinct slots in scrambled order with one duration, run time up, expire
	task automatic run_burst(input int n, input int dur);
		int perm [BANK_SLOTS];
		int j;
		int tmp;
		for (int i = 0; i < BANK_SLOTS; i++)
			perm[i] = i;
		for (int i = BANK_SLOTS - 1; i > 0; i--) begin
			j = $urandom_range(i);
			tmp = perm[i];
			perm[i] = perm[j];
			perm[j] = tmp;
		end
		for (int i = 0; i < n; i++)
			send_start(slot_t'(perm[i]), dur_t'(dur));
		repeat (dur)
			send_tick(1'b1);
		send_expire();
	endtask

	task automatic drain_reports();
		req_ch.valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES)
			@(negedge clk);
	endtask

	task automatic test_tick_cases();
		send_tick_at(frame_t'(0), sub_t'(0));     // same pair as after reset: hold time
		send_tick_at(frame_t'(0), sub_t'(1));
		send_tick_at(frame_t'(0), sub_t'(1));     // repeated pair
		send_tick_at(frame_t'(1023), sub_t'(9));
		send_tick_at(frame_t'(0), sub_t'(0));     // frame number wrap
	endtask

	task automatic test_start_stop_cases();
		send_start(slot_t'(3), '0);               // zero duration on an idle slot
		send_start(slot_t'(0), dur_t'(1));
		send_start(slot_t'(31), '1);
		send_start(slot_t'(0), '0);               // zero duration leaves slot running
		send_stop(slot_t'(17));                   // stop of an idle slot
		send_expire();                            // nothing due yet
		send_tick(1'b1);
		send_start(slot_t'(5), dur_t'(1));
		send_start(slot_t'(5), dur_t'(2));        // restart a running slot
		send_start(slot_t'(6), dur_t'(1));
		send_expire();
		send_stop(slot_t'(31));
		send_tick(1'b1);
		send_tick(1'b1);
		send_expire();
		send_start(slot_t'(2), dur_t'(1));
		send_start(slot_t'(1), dur_t'(1));        // equal deadline, started later
		send_tick(1'b1);
		send_expire();
		send_expire();
	endtask

	task automatic test_full_bank();
		run_burst(BANK_SLOTS, 2);
	endtask

	task automatic test_random_traffic(input int idle, input int stall, input int count);
		int stop_at;
		int pick;
		idle_pct = idle;
		stall_pct = stall;
		stop_at = commands_sent + count;
		while (commands_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 2)
				run_burst($urandom_range(2, BANK_SLOTS), $urandom_range(1, 4));
			else if (pick < 38)
				send_tick($urandom_range(9) != 0);
			else if (pick < 68)
				send_start(slot_t'($urandom), pick_duration());
			else if (pick < 82)
				send_stop(slot_t'($urandom));
			else
				send_expire();
		end
	endtask

	// hold the result side while commands keep coming so the bank backs up
	task automatic test_output_backpressure();
		idle_pct = 0;
		stall_pct = 0;
		hold_requests++;
		for (int i = 0; i < 40; i++) begin
			case (i % 4)
				0: send_tick(1'b1);
				1: send_start(slot_t'($urandom), dur_t'($urandom_range(1, 3)));
				2: send_stop(slot_t'($urandom));
				default: send_expire();
			endcase
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.operation = OP_TICK;
		req_ch.timer_index = '0;
		req_ch.duration = '0;
		req_ch.frame_number = '0;
		req_ch.subframe_number = '0;
		rsp_ch.ready = 1'b0;
		ms_now = '0;
		seen_frame = '0;
		seen_sub = '0;
		arm_count = '0;
		for (int i = 0; i < BANK_SLOTS; i++) begin
			slot_armed[i] = 1'b0;
			slot_deadline_ms[i] = '0;
			slot_arm_seq[i] = '0;
		end
		radio_frame = '0;
		radio_sub = '0;
		idle_pct = 0;
		stall_pct = 0;
		hold_requests = 0;
		hold_served = 0;
		hold_left = 0;
		cycle_count = 0;
		error_count = 0;
		commands_sent = 0;
		results_checked = 0;
		expiry_reports = 0;
		largest_burst = 0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_tick_cases();
		test_start_stop_cases();
		test_full_bank();
		test_random_traffic(0, 0, 50);
		test_random_traffic(81, 0, 50);
		test_random_traffic(0, 81, 50);
		test_random_traffic(26, 26, 50);
		test_output_backpressure();
		drain_reports();

		$display("Covered %0d commands (ticks with new and repeated pairs, starts and restarts,",
			commands_sent);
		$display("zero durations, stops, expiries): %0d results, %0d expiry reports, burst up to %0d",
			results_checked, expiry_reports, largest_burst);
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/fdtb_pkg.sv
rtl/core/fdtb_req_if.sv
rtl/core/fdtb_rsp_if.sv
rtl/core/fdtb_ram.sv
rtl/core/frame_driven_timer_bank.sv
test/tb_frame_driven_timer_bank.sv
